FILE: design/dorq_pkg.sv
// ----------------------------------------------------------------------------
// dorq_pkg
// types and codes shared by the deadline ordered ready queue
// ----------------------------------------------------------------------------
package dorq_pkg;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_IDLE      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam logic [31:0] IDLE_DEADLINE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  task_tag;
		logic [31:0] deadline;
		logic [15:0] task_count;
		logic [7:0]  message_tag;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_task_tag;
		logic [31:0] out_deadline;
		logic [15:0] out_task_count;
		logic [7:0]  out_message_tag;
	} rsp_t;

	typedef struct packed {
		logic [31:0] deadline;
		logic [7:0]  task_tag;
		logic [15:0] task_count;
		logic [7:0]  message_tag;
	} entry_t;

endpackage

FILE: design/deadline_ordered_ready_queue.sv
// ----------------------------------------------------------------------------
// deadline_ordered_ready_queue
// sorted ready queue for earliest-deadline-first scheduling, held in one ram
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Insert, extract and
// remove each return one result on rsp, marked by done for one cycle; the
// receiver cannot stall it.
// The entries live in one single-port synchronous ram kept sorted by deadline.
// Insert, extract and remove walk the queue entry by entry via the ram port:
// insert scans from the tail, moving larger deadlines up by one until it finds
// its slot; extract and remove find the entry and then shift the rest down.
// Busy is high throughout a command and during the done cycle, so a new
// command can be taken in the cycle after done, and one command is in flight
// at a time.
// Reset empties the queue at once; ram contents need no clearing, since only
// entries below the occupancy held at the start of a command are read.
// ----------------------------------------------------------------------------
module deadline_ordered_ready_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dorq_pkg::cmd_t  cmd,
	output logic            done,
	output dorq_pkg::rsp_t  rsp
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_SHRD  = 3'd3;
	localparam logic [2:0] S_SHWR  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	dorq_pkg::entry_t mem [QUEUE_DEPTH];
	dorq_pkg::entry_t rdata_q;

	logic [2:0]    state_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] idx_q;
	dorq_pkg::cmd_t cmd_q;
	dorq_pkg::rsp_t rsp_q;
	logic          done_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	dorq_pkg::entry_t wdata;
	dorq_pkg::entry_t new_e;

	function automatic dorq_pkg::rsp_t status_only(logic [2:0] s);
		status_only = '0;
		status_only.status = s;
	endfunction

	assign new_e = '{deadline: cmd_q.deadline, task_tag: cmd_q.task_tag,
		task_count: cmd_q.task_count, message_tag: cmd_q.message_tag};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	// insert: idx_q counts down, reading idx_q-1 and writing it at idx_q
	// extract/remove: idx_q scans up in S_RD/S_CHK, then shifts down
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = idx_q[AW-1:0];
		raddr = idx_q[AW-1:0];
		wdata = rdata_q;
		unique case (state_q)
			S_RD: begin
				re = 1'b1;
				if (cmd_q.op == dorq_pkg::OP_INSERT)
					raddr = AW'(idx_q - CW'(1));
			end
			S_CHK: begin
				if (cmd_q.op == dorq_pkg::OP_INSERT) begin
					we = 1'b1;
					if (rdata_q.deadline > cmd_q.deadline) wdata = rdata_q;
					else wdata = new_e;
				end
			end
			S_SHRD: begin
				re = 1'b1;
				raddr = AW'(idx_q + CW'(1));
			end
			S_SHWR: begin
				we = 1'b1;
			end
			S_DONE: begin
				if (cmd_q.op == dorq_pkg::OP_INSERT && idx_q == '0 &&
						rsp_q.status == dorq_pkg::ST_OK) begin
					we = 1'b1;
					wdata = new_e;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			idx_q <= '0;
			done_q <= 1'b0;
			cmd_q <= '0;
			rsp_q <= '0;
		end else begin
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (start && !done_q) begin
						cmd_q <= cmd;
						unique case (cmd.op)
							dorq_pkg::OP_INSERT: begin
								idx_q <= occ_q;
								if (occ_q == CW'(QUEUE_DEPTH)) begin
									rsp_q <= status_only(dorq_pkg::ST_FULL);
									state_q <= S_DONE;
								end else begin
									rsp_q <= status_only(dorq_pkg::ST_OK);
									occ_q <= occ_q + CW'(1);
									state_q <= (occ_q != '0) ? S_RD : S_DONE;
								end
							end
							dorq_pkg::OP_EXTRACT: begin
								idx_q <= '0;
								if (occ_q == '0) begin
									rsp_q <= status_only(dorq_pkg::ST_EMPTY);
									state_q <= S_DONE;
								end else begin
									rsp_q <= status_only(dorq_pkg::ST_OK);
									state_q <= S_RD;
								end
							end
							dorq_pkg::OP_REMOVE: begin
								idx_q <= '0;
								if (occ_q == '0) begin
									rsp_q <= status_only(dorq_pkg::ST_NOT_FOUND);
									state_q <= S_DONE;
								end else begin
									rsp_q <= status_only(dorq_pkg::ST_OK);
									state_q <= S_RD;
								end
							end
							default: begin
								idx_q <= '0;
								rsp_q <= status_only(dorq_pkg::ST_OK);
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (cmd_q.op == dorq_pkg::OP_INSERT) begin
						if (rdata_q.deadline > cmd_q.deadline) begin
							idx_q <= idx_q - CW'(1);
							state_q <= (idx_q == CW'(1)) ? S_DONE : S_RD;
						end else
							state_q <= S_DONE;
					end else if (cmd_q.op == dorq_pkg::OP_EXTRACT &&
							rdata_q.deadline == dorq_pkg::IDLE_DEADLINE) begin
						rsp_q.status <= dorq_pkg::ST_IDLE;
						state_q <= S_DONE;
					end else if (cmd_q.op == dorq_pkg::OP_EXTRACT ||
							rdata_q.task_tag == cmd_q.task_tag) begin
						rsp_q <= '{status: dorq_pkg::ST_OK,
							out_task_tag: rdata_q.task_tag,
							out_deadline: rdata_q.deadline,
							out_task_count: rdata_q.task_count,
							out_message_tag: rdata_q.message_tag};
						occ_q <= occ_q - CW'(1);
						state_q <= (idx_q + CW'(1) < occ_q) ? S_SHRD : S_DONE;
					end else if (idx_q + CW'(1) < occ_q) begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_RD;
					end else begin
						rsp_q.status <= dorq_pkg::ST_NOT_FOUND;
						state_q <= S_DONE;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					idx_q <= idx_q + CW'(1);
					state_q <= (idx_q + CW'(2) < occ_q + CW'(1)) ? S_SHRD : S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the insert position write also happens in S_CHK when an entry with an equal
	// or smaller deadline stops the scan; in S_DONE only when the scan ran to index zero or the queue was empty
	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;
	assign rsp = rsp_q;

	property occ_bound;
		@(posedge clk) disable iff (!arst_n) occ_q <= CW'(QUEUE_DEPTH);
	endproperty
	assert property (occ_bound) else $error("occupancy above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> done_q)
		else $error("done missing after completion");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("done outside idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised on accepted transaction");

endmodule
